[hw/rtl/skvt_pkg.sv]
package skvt_pkg;

	// Default sizes of the table.
	localparam int DEPTH_DEF       = 64;
	localparam int KEY_WIDTH_DEF   = 8;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int CMD_WIDTH    = 2;
	localparam int STATUS_WIDTH = 2;

	typedef logic [CMD_WIDTH-1:0]    cmd_t;
	typedef logic [STATUS_WIDTH-1:0] status_t;

	localparam cmd_t CMD_PUT    = 2'd0;
	localparam cmd_t CMD_LOOKUP = 2'd1;
	localparam cmd_t CMD_REMOVE = 2'd2;
	localparam cmd_t CMD_CLEAR  = 2'd3;

	localparam status_t STATUS_DONE    = 2'd0;
	localparam status_t STATUS_ABSENT  = 2'd1;
	localparam status_t STATUS_FULL    = 2'd2;
	localparam status_t STATUS_PRESENT = 2'd3;

	// Update strobes broadcast to every cell of the chain.
	typedef struct packed {
		logic append;
		logic shift;
	} cell_ctl_t;

endpackage

[hw/rtl/skvt_ifs.sv]
interface skvt_req_if import skvt_pkg::*; #(
	parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
	logic                   valid;
	logic                   ready;
	cmd_t                   cmd;
	logic [KEY_WIDTH-1:0]   key;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, cmd, key, value, input ready);
	modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface skvt_rsp_if import skvt_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int COUNT_W     = $clog2(DEPTH_DEF + 1)
) ();
	logic                   valid;
	logic                   ready;
	status_t                status;
	logic                   found;
	logic [VALUE_WIDTH-1:0] read_value;
	logic [COUNT_W-1:0]     entry_count;

	modport source (output valid, status, found, read_value, entry_count, input ready);
	modport sink   (input valid, status, found, read_value, entry_count, output ready);
endinterface

[hw/rtl/skvt_cell.sv]
module skvt_cell import skvt_pkg::*; #(
	parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  cell_ctl_t              ctl,
	input  logic                   live,
	input  logic                   tail,
	input  logic [KEY_WIDTH-1:0]   key,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [KEY_WIDTH-1:0]   next_key,
	input  logic [VALUE_WIDTH-1:0] next_value,
	input  logic                   prefix_in,
	input  logic [VALUE_WIDTH-1:0] rd_in,
	output logic                   hit,
	output logic                   prefix_out,
	output logic [VALUE_WIDTH-1:0] rd_out,
	output logic [KEY_WIDTH-1:0]   key_out,
	output logic [VALUE_WIDTH-1:0] value_out
);

	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;

	// A live entry whose key matches the broadcast key.
	assign hit        = live && (key_q == key);
	// Set from the hit cell onward, so every later cell knows to move down on remove.
	assign prefix_out = prefix_in | hit;
	assign rd_out     = rd_in | (hit ? value_q : '0);
	assign key_out    = key_q;
	assign value_out  = value_q;

	always_ff @(posedge clk) begin
		if (ctl.append && tail) begin
			key_q   <= key;
			value_q <= value;
		end else if (ctl.shift && prefix_out) begin
			key_q   <= next_key;
			value_q <= next_value;
		end
	end

endmodule

[hw/rtl/small_key_value_table.sv]
// A request is captured in the request registers, then searched and applied
// through the cell chain in the update state; its result is then loaded into
// the result register. No new request is taken before that update state ends.
// Reset clears the entry count, the control state and the result valid flag;
// the key and value cells are not cleared and are read only below the count.
module small_key_value_table import skvt_pkg::*; #(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	skvt_req_if.sink   req,
	skvt_rsp_if.source rsp
);

	localparam int COUNT_W = $clog2(DEPTH + 1);

	// Two-state sequencer: wait for a request, then search and update.
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;

	// The request is captured so that the broadcast key is a clean register output.
	cmd_t                   cmd_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;

	// Number of live entries; cell i holds a live entry when i is below it.
	logic [COUNT_W-1:0] count_q;

	// Result register, which decouples the response side from the table.
	logic                   rsp_valid_q;
	status_t                status_q;
	logic                   found_q;
	logic [VALUE_WIDTH-1:0] read_value_q;
	logic [COUNT_W-1:0]     entry_count_q;

	// Chain signals. The prefix and read data ripple from cell 0 upward,
	// while stored entries are offered to the neighbor below for a remove.
	logic [DEPTH:0]         prefix;
	logic [VALUE_WIDTH-1:0] rd_chain [DEPTH+1];
	logic [KEY_WIDTH-1:0]   key_st   [DEPTH];
	logic [VALUE_WIDTH-1:0] value_st [DEPTH];
	logic [DEPTH-1:0]       live;
	logic [DEPTH-1:0]       tail;
	logic [DEPTH-1:0]       hit;

	logic      exec;
	logic      found;
	logic      full;
	cell_ctl_t ctl;

	status_t            status_d;
	logic [COUNT_W-1:0] count_d;

	assign exec  = (state_q == ST_EXEC);
	assign found = prefix[DEPTH];
	assign full  = (count_q == COUNT_W'(DEPTH));

	// A new request is taken only when the result register is free or is
	// being emptied in the same cycle, so the update cycle can always load it.
	assign req.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);

	// Put appends at the tail cell; remove moves every cell from the hit upward.
	assign ctl.append = exec && (cmd_q == CMD_PUT) && !found && !full;
	assign ctl.shift  = exec && (cmd_q == CMD_REMOVE) && found;

	assign prefix[0]   = 1'b0;
	assign rd_chain[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_WIDTH-1:0]   nkey;
		logic [VALUE_WIDTH-1:0] nvalue;

		assign live[i] = (COUNT_W'(i) < count_q);
		assign tail[i] = (COUNT_W'(i) == count_q);

		// The top cell has no neighbor above; what it takes on a remove
		// lies beyond the new count and is never read.
		if (i == DEPTH - 1) begin : g_top
			assign nkey   = '0;
			assign nvalue = '0;
		end else begin : g_mid
			assign nkey   = key_st[i+1];
			assign nvalue = value_st[i+1];
		end

		skvt_cell #(
			.KEY_WIDTH   (KEY_WIDTH),
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.live       (live[i]),
			.tail       (tail[i]),
			.key        (key_q),
			.value      (value_q),
			.next_key   (nkey),
			.next_value (nvalue),
			.prefix_in  (prefix[i]),
			.rd_in      (rd_chain[i]),
			.hit        (hit[i]),
			.prefix_out (prefix[i+1]),
			.rd_out     (rd_chain[i+1]),
			.key_out    (key_st[i]),
			.value_out  (value_st[i])
		);
	end

	// Status and new count of the request in the update cycle.
	always_comb begin
		status_d = STATUS_DONE;
		count_d  = count_q;
		unique case (cmd_q) inside
			CMD_PUT: begin
				if (found) begin
					status_d = STATUS_PRESENT;
				end else if (full) begin
					status_d = STATUS_FULL;
				end else begin
					count_d = count_q + COUNT_W'(1);
				end
			end
			CMD_LOOKUP, CMD_REMOVE: begin
				if (!found) begin
					status_d = STATUS_ABSENT;
				end else if (cmd_q == CMD_REMOVE) begin
					count_d = count_q - COUNT_W'(1);
				end
			end
			default: begin
				count_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q   <= req.cmd;
			key_q   <= req.key;
			value_q <= req.value;
		end
		if (exec) begin
			status_q      <= status_d;
			found_q       <= found && (cmd_q != CMD_CLEAR);
			read_value_q  <= (cmd_q == CMD_LOOKUP) ? rd_chain[DEPTH] : '0;
			entry_count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.found       = found_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.entry_count = entry_count_q;

`ifndef SYNTHESIS
	// Keys are kept unique, so at most one live cell can match.
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		exec |-> $onehot0(hit))
		else $error("more than one live cell matches the key");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(DEPTH))
		else $error("entry count exceeds the table depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && (cmd_q == CMD_CLEAR)) |=> (count_q == '0) && (rsp.entry_count == '0))
		else $error("clear left entries in the table");

	a_result_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(exec))
		else $error("result appeared without an update cycle");

	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		exec |-> !req.ready)
		else $error("request taken during the update cycle");
`endif

endmodule

[tb/sv/tb_top.sv]
module tb_top;
	import skvt_pkg::*;

	// Table geometry under test, taken from the package defaults.
	localparam int TABLE_DEPTH = DEPTH_DEF;
	localparam int KEY_W       = KEY_WIDTH_DEF;
	localparam int VALUE_W     = VALUE_WIDTH_DEF;
	localparam int COUNT_W     = $clog2(DEPTH_DEF + 1);

	// Stimulus size and run bounds. The request count only says when stimulus
	// stops. The cycle limit covers every request waiting out the longest
	// sender gap and the longest receiver stall, plus both hold-offs,
	// several times over.
	localparam int unsigned TOTAL_ITEMS   = 1050;
	localparam int unsigned HOLD_CYCLES   = 150;
	localparam int unsigned DRAIN_CYCLES  = 12;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned REPORT_LIMIT  = 10;

	// One predicted response of the table.
	typedef struct {
		status_t              status;
		logic                 found;
		logic [VALUE_W-1:0]   read_value;
		logic [COUNT_W-1:0]   entry_count;
	} table_result_t;

	// Scoreboard: keeps its own packed copy of the table, predicts the
	// response of every accepted request and compares responses in order.
	class table_scoreboard;
		logic [KEY_W-1:0]   stored_keys [TABLE_DEPTH];
		logic [VALUE_W-1:0] stored_values [TABLE_DEPTH];
		int unsigned        live_count;
		table_result_t      expected_q [$];
		int unsigned        mismatches;
		int unsigned        requests_noted;
		int unsigned        results_checked;
		int unsigned        status_tally [4];
		int unsigned        peak_count;

		function new();
			live_count      = 0;
			mismatches      = 0;
			requests_noted  = 0;
			results_checked = 0;
			peak_count      = 0;
			foreach (status_tally[i])
				status_tally[i] = 0;
		endfunction

		function void note_request(cmd_t cmd, logic [KEY_W-1:0] key,
				logic [VALUE_W-1:0] value);
			table_result_t r;
			int unsigned   slot;
			int unsigned   j;
			r.status      = STATUS_DONE;
			r.found       = 1'b0;
			r.read_value  = '0;
			requests_noted++;
			if (cmd == CMD_CLEAR) begin
				live_count = 0;
			end else begin
				// The search is bounded by the live count.
				slot = live_count;
				for (j = 0; j < live_count; j++) begin
					if (stored_keys[j] == key) begin
						slot = j;
						break;
					end
				end
				r.found = (slot < live_count);
				case (cmd)
					CMD_PUT: begin
						if (r.found) begin
							r.status = STATUS_PRESENT;
						end else if (live_count >= TABLE_DEPTH) begin
							r.status = STATUS_FULL;
						end else begin
							stored_keys[live_count]   = key;
							stored_values[live_count] = value;
							live_count++;
						end
					end
					CMD_LOOKUP: begin
						if (r.found)
							r.read_value = stored_values[slot];
						else
							r.status = STATUS_ABSENT;
					end
					default: begin
						if (r.found) begin
							for (j = slot; j + 1 < live_count; j++) begin
								stored_keys[j]   = stored_keys[j + 1];
								stored_values[j] = stored_values[j + 1];
							end
							live_count--;
						end else begin
							r.status = STATUS_ABSENT;
						end
					end
				endcase
			end
			if (live_count > peak_count)
				peak_count = live_count;
			r.entry_count = COUNT_W'(live_count);
			expected_q.push_back(r);
		endfunction

		function void check_result(status_t status, logic found,
				logic [VALUE_W-1:0] read_value, logic [COUNT_W-1:0] entry_count);
			table_result_t e;
			results_checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("Response %0d arrived with no request outstanding",
						results_checked);
				return;
			end
			e = expected_q.pop_front();
			status_tally[e.status]++;
			if (status !== e.status || found !== e.found ||
					read_value !== e.read_value || entry_count !== e.entry_count) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("Response %0d mismatch: status exp %0d got %0d, found exp %0b got %0b",
						results_checked, e.status, status, e.found, found);
					$display("  read_value exp %h got %h, entry_count exp %0d got %0d",
						e.read_value, read_value, e.entry_count, entry_count);
				end
			end
		endfunction

		function int unsigned pending_count();
			return expected_q.size();
		endfunction

		function logic [KEY_W-1:0] key_at(int unsigned idx);
			return stored_keys[idx];
		endfunction
	endclass

	logic clk;
	logic arst_n;

	skvt_req_if #(.KEY_WIDTH(KEY_W), .VALUE_WIDTH(VALUE_W)) req_if ();
	skvt_rsp_if #(.VALUE_WIDTH(VALUE_W), .COUNT_W(COUNT_W)) rsp_if ();

	small_key_value_table #(
		.DEPTH       (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_W),
		.VALUE_WIDTH (VALUE_W)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	table_scoreboard sb;

	// Shared between the request driver and the response sink: a raised flag
	// asks the sink to hold ready low for a long stretch so that the table's
	// pipeline fills up and backpressures the request side.
	bit hold_request;

	// Sender gap state: a nonzero count makes the sender offer requests without gaps.
	int unsigned no_gap_left;

	int unsigned cycle_count;

	// Clock with a period of four time units.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d responses outstanding",
				cycle_count, sb.pending_count());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Response monitor: a transfer happens at a rising edge where valid and
	// ready are both high. Ready is driven at the falling edge, so both sides
	// are stable here.
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_result(rsp_if.status, rsp_if.found, rsp_if.read_value,
				rsp_if.entry_count);
	end

	// Response sink: ready moves at the falling edge in random stretches.
	// Most stalls are short, a few are long, and some stretches keep ready
	// high throughout. A pending hold request overrides all of this.
	initial begin
		int unsigned r;
		int unsigned len;
		rsp_if.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					rsp_if.ready <= 1'b1;
					len = $urandom_range(20, 80);
				end else if (r < 60) begin
					rsp_if.ready <= 1'b1;
					len = $urandom_range(1, 4);
				end else if (r < 93) begin
					rsp_if.ready <= 1'b0;
					len = $urandom_range(1, 3);
				end else begin
					rsp_if.ready <= 1'b0;
					len = $urandom_range(6, 40);
				end
				repeat (len) @(negedge clk);
			end
		end
	end

	// Idle cycles before the next request: mostly none or a few, sometimes
	// a long gap, and now and then a run of requests offered without a gap.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_gap_left > 0) begin
			no_gap_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			no_gap_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Values lean on the signed extremes, zero and all ones.
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Offers one request and waits for its transfer. The payload and valid
	// change only at falling edges; when the next request follows without a
	// gap, valid simply stays high.
	task automatic send_request(cmd_t cmd, logic [KEY_W-1:0] key,
			logic [VALUE_W-1:0] value);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.cmd   <= cmd;
		req_if.key   <= key;
		req_if.value <= value;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sb.note_request(cmd, key, value);
		@(negedge clk);
	endtask

	// Ordinary traffic on a narrow window of keys, so that puts collide,
	// lookups hit and removes find their targets. Clears are rare so the
	// table has room to grow.
	task automatic mixed_burst(int unsigned len);
		logic [KEY_W-1:0] base;
		int unsigned      span;
		int unsigned      r;
		int unsigned      i;
		cmd_t             cmd;
		base = KEY_W'($urandom);
		span = $urandom_range(3, 40);
		for (i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				cmd = CMD_PUT;
			else if (r < 70)
				cmd = CMD_LOOKUP;
			else if (r < 97)
				cmd = CMD_REMOVE;
			else
				cmd = CMD_CLEAR;
			send_request(cmd, base + KEY_W'($urandom_range(0, span)), pick_value());
		end
	endtask

	// Fills the table to capacity, then pushes puts against the full table,
	// re-puts a present key, and works on entries in the middle so that
	// removals shift a long tail.
	task automatic fill_burst();
		int unsigned i;
		while (sb.live_count < TABLE_DEPTH)
			send_request(CMD_PUT, KEY_W'($urandom), pick_value());
		repeat ($urandom_range(1, 4))
			send_request(CMD_PUT, KEY_W'($urandom), pick_value());
		send_request(CMD_PUT, sb.key_at($urandom_range(0, sb.live_count - 1)),
			pick_value());
		for (i = 0; i < 6 && sb.live_count > 0; i++) begin
			send_request(CMD_LOOKUP,
				sb.key_at($urandom_range(0, sb.live_count - 1)), pick_value());
			send_request(CMD_REMOVE,
				sb.key_at($urandom_range(0, sb.live_count - 1)), pick_value());
		end
	endtask

	// Empties the table mostly through removals of live keys.
	task automatic drain_burst(int unsigned len);
		int unsigned i;
		int unsigned r;
		for (i = 0; i < len && sb.live_count > 0; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				send_request(CMD_REMOVE,
					sb.key_at($urandom_range(0, sb.live_count - 1)), pick_value());
			else if (r < 90)
				send_request(CMD_LOOKUP,
					sb.key_at($urandom_range(0, sb.live_count - 1)), pick_value());
			else
				send_request(CMD_LOOKUP, KEY_W'($urandom), pick_value());
		end
	endtask

	// Unshaped requests over the whole field ranges.
	task automatic noise_burst(int unsigned len);
		repeat (len)
			send_request(cmd_t'($urandom_range(0, 3)), KEY_W'($urandom), $urandom);
	endtask

	initial begin
		int unsigned r;
		bit          second_hold_sent;
		sb = new();
		hold_request     = 1'b0;
		second_hold_sent = 1'b0;
		no_gap_left      = 0;
		cycle_count      = 0;
		req_if.valid = 1'b0;
		req_if.cmd   = CMD_PUT;
		req_if.key   = '0;
		req_if.value = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: commands against the empty table, the key and value
		// extremes, a put of a present key that must leave the old value in
		// place, removal of the first entry so the rest shift down, removal
		// of the last entry, and a clear followed by a miss.
		send_request(CMD_LOOKUP, 8'h00, 32'h0000_0000);
		send_request(CMD_REMOVE, 8'hFF, 32'h0000_0000);
		send_request(CMD_CLEAR,  8'h00, 32'h0000_0000);
		send_request(CMD_PUT,    8'h00, 32'h8000_0000);
		send_request(CMD_PUT,    8'hFF, 32'h7FFF_FFFF);
		send_request(CMD_PUT,    8'h00, 32'h0000_0001);
		send_request(CMD_LOOKUP, 8'h00, 32'h0000_0000);
		send_request(CMD_LOOKUP, 8'hFF, 32'h0000_0000);
		send_request(CMD_PUT,    8'h55, 32'hAAAA_AAAA);
		send_request(CMD_PUT,    8'hAA, 32'h5555_5555);
		send_request(CMD_REMOVE, 8'h00, 32'hFFFF_FFFF);
		send_request(CMD_LOOKUP, 8'hFF, 32'h0000_0000);
		send_request(CMD_LOOKUP, 8'h00, 32'h0000_0000);
		send_request(CMD_REMOVE, 8'h00, 32'h0000_0000);
		send_request(CMD_LOOKUP, 8'hAA, 32'h0000_0000);
		send_request(CMD_REMOVE, 8'hAA, 32'h0000_0000);
		send_request(CMD_PUT,    8'hAA, 32'h0000_0000);
		send_request(CMD_LOOKUP, 8'h55, 32'h0000_0000);
		send_request(CMD_CLEAR,  8'hFF, 32'hFFFF_FFFF);
		send_request(CMD_LOOKUP, 8'hFF, 32'h0000_0000);
		send_request(CMD_PUT,    8'hFF, 32'hFFFF_FFFF);

		// Random part. It opens with a long receiver hold-off and a fill to
		// capacity, so the full-table case is reached early; a second
		// hold-off lands about halfway through.
		hold_request = 1'b1;
		fill_burst();
		while (sb.requests_noted < TOTAL_ITEMS) begin
			if (!second_hold_sent && sb.requests_noted > TOTAL_ITEMS / 2) begin
				hold_request     = 1'b1;
				second_hold_sent = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 55)
				mixed_burst($urandom_range(20, 60));
			else if (r < 72)
				fill_burst();
			else if (r < 87)
				drain_burst($urandom_range(5, 40));
			else
				noise_burst($urandom_range(10, 30));
		end
		req_if.valid <= 1'b0;

		// Wait for every outstanding response, then wait out DRAIN_CYCLES so a
		// stray extra response would still be caught.
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests and %0d responses; occupancy peaked at %0d of %0d.",
			sb.requests_noted, sb.results_checked, sb.peak_count, TABLE_DEPTH);
		$display("Outcomes: %0d done, %0d absent, %0d full, %0d present; %0d mismatches.",
			sb.status_tally[STATUS_DONE], sb.status_tally[STATUS_ABSENT],
			sb.status_tally[STATUS_FULL], sb.status_tally[STATUS_PRESENT],
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_count() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
